// ===== sv/pid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants for the PID regulator step
// Register indexes, reset values, sequencer codes and the request/response
// structs of the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package pid_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int OPND_W    = 34;
	localparam int MAG_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int QUO_W     = MAG_W + FRAC_W;
	localparam int CNT_W     = 6;

	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MAG_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd4;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	localparam logic signed [DATA_W-1:0] GAIN_P_RST  = 32'sd65536;
	localparam logic signed [DATA_W-1:0] GAIN_I_RST  = 32'sd6554;
	localparam logic signed [DATA_W-1:0] GAIN_D_RST  = 32'sd3277;
	localparam logic signed [DATA_W-1:0] OUT_MIN_RST = S32_MIN;
	localparam logic signed [DATA_W-1:0] OUT_MAX_RST = S32_MAX;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_WAIT,
		ST_INTEG,
		ST_CLAMP,
		ST_SUM
	} state_t;

	typedef enum logic [2:0] {
		JOB_ERRDT,
		JOB_BND0,
		JOB_BND1,
		JOB_DERIV,
		JOB_TP,
		JOB_TI,
		JOB_TD
	} job_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic                     start;
		op_t                      op;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] value;
	} md_rsp_t;

endpackage

// ===== sv/pid_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_muldiv: bit-serial Q16.16 multiply / divide unit
// Sign-magnitude shift-add multiply (one multiplier bit per cycle, floor
// after the 16-bit shift) and restoring divide (one quotient bit per cycle,
// dividend scaled by 2^16, truncated toward zero). Result saturates to 32 bits.
// ----------------------------------------------------------------------------
module pid_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  pid_pkg::md_req_t req,
	output pid_pkg::md_rsp_t rsp
);
	import pid_pkg::*;

	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	op_t                      op_q;
	logic                     neg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [2*MAG_W-1:0]       work_q;
	logic [MAG_W-1:0]         rem_q;
	logic [MAG_W-1:0]         opnd_q;
	logic signed [DATA_W-1:0] result_q;

	logic [MAG_W:0]   mul_sum;
	logic [MAG_W:0]   div_trial;
	logic [MAG_W+1:0] div_diff;
	logic             div_ge;
	logic [QUO_W-1:0] mag;
	logic signed [DATA_W-1:0] sat_val;

	function automatic logic [MAG_W-1:0] mag32(input logic signed [OPND_W-1:0] v);
		logic [OPND_W-1:0] m;
		m = v[OPND_W-1] ? OPND_W'(-v) : OPND_W'(v);
		return m[MAG_W-1:0];
	endfunction

	always_comb begin
		mul_sum   = {1'b0, work_q[2*MAG_W-1:MAG_W]} + (work_q[0] ? {1'b0, opnd_q} : '0);
		div_trial = {rem_q, work_q[QUO_W-1]};
		div_diff  = {1'b0, div_trial} - {2'b0, opnd_q};
		div_ge    = !div_diff[MAG_W+1];
		// negative product: floor of -P/2^16 is -(ceil of P/2^16)
		if (op_q == OP_MUL) begin
			mag = work_q[2*MAG_W-1:FRAC_W] + QUO_W'(neg_q && (|work_q[FRAC_W-1:0]));
		end else begin
			mag = work_q[QUO_W-1:0];
		end
		if (neg_q) begin
			if (mag > QUO_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
				sat_val = S32_MIN;
			end else begin
				sat_val = DATA_W'(~mag[DATA_W-1:0] + 1'b1);
			end
		end else begin
			if (mag > QUO_W'(S32_MAX)) begin
				sat_val = S32_MAX;
			end else begin
				sat_val = mag[DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			neg_q  <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
			opnd_q <= (req.op == OP_MUL) ? mag32(req.a) : mag32(req.b);
			rem_q  <= '0;
			if (req.op == OP_MUL) begin
				work_q <= {{MAG_W{1'b0}}, mag32(req.b)};
			end else begin
				work_q <= {{(2*MAG_W-QUO_W){1'b0}}, mag32(req.a), {FRAC_W{1'b0}}};
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				work_q <= {mul_sum, work_q[MAG_W-1:1]};
			end else begin
				rem_q  <= div_ge ? div_diff[MAG_W-1:0] : div_trial[MAG_W-1:0];
				work_q <= {work_q[2*MAG_W-1:QUO_W], work_q[QUO_W-2:0], div_ge};
			end
		end
		if (fin_q) begin
			result_q <= sat_val;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = result_q;

endmodule

// ===== sv/pid_controller_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_step_top: Q16.16 PID regulator step with integral clamp
// Sequencer around one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A clear request or a request with zero
// step_time gives its result in the cycle after it is taken. A control step runs
// five serial operations through the shared multiply/divide unit, or seven when
// gain_i is nonzero, since the two integral bounds then cost two extra divides.
// A finished result waits in the output register and the next request is
// accepted as soon as that register can take it. Configuration is to be written
// by the user only while no request is in flight; the block itself does not
// check this.
// ----------------------------------------------------------------------------
module pid_controller_step_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [pid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pid_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic signed [pid_pkg::DATA_W-1:0]   target,
	input  logic signed [pid_pkg::DATA_W-1:0]   measured,
	input  logic [pid_pkg::DATA_W-1:0]          step_time,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pid_pkg::DATA_W-1:0]   drive
);
	import pid_pkg::*;

	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q, out_min_q, out_max_q;
	state_t state_q, state_d;
	job_t   job_q, job_d;

	logic signed [DATA_W-1:0] err_q, acc_q, last_q, integ_q, b0_q, b1_q, deriv_q;
	logic [DATA_W-1:0]        dt_q;
	logic signed [DATA_W+1:0] sum_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;

	md_req_t md_req;
	md_rsp_t md_rsp;

	logic                     in_take, out_free;
	logic signed [DATA_W:0]   err_wide, integ_wide;
	logic signed [DATA_W-1:0] err_sat, integ_sat, bnd_lo, bnd_hi, integ_clamped;
	logic signed [DATA_W+1:0] sum_next, lo_w, hi_w;
	logic signed [DATA_W-1:0] sum_clamped;
	logic signed [DATA_W:0]   err_delta;

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		if (v[DATA_W] != v[DATA_W-1]) begin
			return v[DATA_W] ? S32_MIN : S32_MAX;
		end
		return v[DATA_W-1:0];
	endfunction

	pid_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && !action && (step_time != '0)) begin
					state_d = ST_LAUNCH;
					job_d   = JOB_ERRDT;
				end
			end
			ST_LAUNCH: state_d = ST_WAIT;
			ST_WAIT: begin
				if (md_rsp.done) begin
					case (job_q)
						JOB_ERRDT: state_d = ST_INTEG;
						JOB_BND0: begin
							state_d = ST_LAUNCH;
							job_d   = JOB_BND1;
						end
						JOB_BND1: state_d = ST_CLAMP;
						JOB_DERIV: begin
							state_d = ST_LAUNCH;
							job_d   = JOB_TP;
						end
						JOB_TP: begin
							state_d = ST_LAUNCH;
							job_d   = JOB_TI;
						end
						JOB_TI: begin
							state_d = ST_LAUNCH;
							job_d   = JOB_TD;
						end
						JOB_TD: state_d = ST_SUM;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INTEG: begin
				state_d = ST_LAUNCH;
				job_d   = (gain_i_q != '0) ? JOB_BND0 : JOB_DERIV;
			end
			ST_CLAMP: begin
				state_d = ST_LAUNCH;
				job_d   = JOB_DERIV;
			end
			ST_SUM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		in_stall   = (state_q != ST_IDLE) || !out_free;
		err_wide   = DATA_W'(0) + ((DATA_W+1)'(target) - (DATA_W+1)'(measured));
		err_sat    = sat33(err_wide);
		err_delta  = (DATA_W+1)'(err_q) - (DATA_W+1)'(last_q);
		integ_wide = (DATA_W+1)'(acc_q) + (DATA_W+1)'(integ_q);
		integ_sat  = sat33(integ_wide);

		bnd_lo = (b0_q < b1_q) ? b0_q : b1_q;
		bnd_hi = (b0_q < b1_q) ? b1_q : b0_q;
		integ_clamped = integ_q;
		if (integ_clamped < bnd_lo) integ_clamped = bnd_lo;
		if (integ_clamped > bnd_hi) integ_clamped = bnd_hi;

		sum_next = sum_q + (DATA_W+2)'(md_rsp.value);
		lo_w     = (DATA_W+2)'(out_min_q);
		hi_w     = (DATA_W+2)'(out_max_q);
		// raise to out_min first, then out_max wins when limits cross
		if (sum_q < lo_w) begin
			sum_clamped = (out_min_q > out_max_q) ? out_max_q : out_min_q;
		end else if (sum_q > hi_w) begin
			sum_clamped = out_max_q;
		end else begin
			sum_clamped = sum_q[DATA_W-1:0];
		end

		md_req.start = (state_q == ST_LAUNCH);
		md_req.op    = OP_MUL;
		md_req.a     = '0;
		md_req.b     = '0;
		case (job_q)
			JOB_ERRDT: begin
				md_req.a = OPND_W'(err_q);
				md_req.b = OPND_W'({1'b0, dt_q});
			end
			JOB_BND0: begin
				md_req.op = OP_DIV;
				md_req.a  = OPND_W'(out_min_q);
				md_req.b  = OPND_W'(gain_i_q);
			end
			JOB_BND1: begin
				md_req.op = OP_DIV;
				md_req.a  = OPND_W'(out_max_q);
				md_req.b  = OPND_W'(gain_i_q);
			end
			JOB_DERIV: begin
				md_req.op = OP_DIV;
				md_req.a  = OPND_W'(err_delta);
				md_req.b  = OPND_W'({1'b0, dt_q});
			end
			JOB_TP: begin
				md_req.a = OPND_W'(gain_p_q);
				md_req.b = OPND_W'(err_q);
			end
			JOB_TI: begin
				md_req.a = OPND_W'(gain_i_q);
				md_req.b = OPND_W'(integ_q);
			end
			JOB_TD: begin
				md_req.a = OPND_W'(gain_d_q);
				md_req.b = OPND_W'(deriv_q);
			end
			default: begin
				md_req.a = '0;
				md_req.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_ERRDT;
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			out_min_q   <= OUT_MIN_RST;
			out_max_q   <= OUT_MAX_RST;
			acc_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			if (cfg_en) begin
				case (cfg_index)
					CFG_GAIN_P:  gain_p_q  <= cfg_data;
					CFG_GAIN_I:  gain_i_q  <= cfg_data;
					CFG_GAIN_D:  gain_d_q  <= cfg_data;
					CFG_OUT_MIN: out_min_q <= cfg_data;
					CFG_OUT_MAX: out_max_q <= cfg_data;
					default: ;
				endcase
			end
			if ((in_take && (action || (step_time == '0)))
			    || ((state_q == ST_SUM) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_take && action) begin
				acc_q  <= '0;
				last_q <= '0;
			end
			if ((state_q == ST_SUM) && out_free) begin
				acc_q  <= integ_q;
				last_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			err_q   <= err_sat;
			dt_q    <= step_time;
			drive_q <= '0;
		end
		if ((state_q == ST_WAIT) && md_rsp.done) begin
			case (job_q)
				JOB_ERRDT: integ_q <= md_rsp.value;
				JOB_BND0:  b0_q    <= md_rsp.value;
				JOB_BND1:  b1_q    <= md_rsp.value;
				JOB_DERIV: deriv_q <= md_rsp.value;
				JOB_TP:    sum_q   <= (DATA_W+2)'(md_rsp.value);
				JOB_TI:    sum_q   <= sum_next;
				JOB_TD:    sum_q   <= sum_next;
				default: ;
			endcase
		end
		if (state_q == ST_INTEG) begin
			integ_q <= integ_sat;
		end
		if (state_q == ST_CLAMP) begin
			integ_q <= integ_clamped;
		end
		if ((state_q == ST_SUM) && out_free) begin
			drive_q <= sum_clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// unit answers only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_WAIT))
		else $error("muldiv done outside wait state");

	a_step_launches: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !action && (step_time != '0))
		|=> (state_q == ST_LAUNCH) && (job_q == JOB_ERRDT))
		else $error("control step did not start the sequence");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action)
		|=> (acc_q == '0) && (last_q == '0) && out_valid_q && (drive_q == '0))
		else $error("clear request did not zero state and give 0");

	a_result_one_cycle_later: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SUM) && out_free) |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished step did not load the output register");

endmodule
